/* rtl/core/sbd_pkg.sv */
// Shared types and constants for the shuffle bag draw/refill block.
// No dependencies; compiled first.
package sbd_pkg;

    localparam int MODE_W    = 2;
    localparam int WORD_W    = 32;
    localparam int RANGE_W   = 7;
    localparam int OUT_VAL_W = 6;
    localparam int BIT_CNT_W = $clog2(WORD_W);

    localparam logic [RANGE_W-1:0] RANGE_END_RST = 7'd40;

    localparam logic [MODE_W-1:0] MODE_DRAW        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW_REFILL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REFILL      = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_REFILL,
        S_DIV,
        S_FETCH,
        S_SHIFT,
        S_OUT
    } t_state;

endpackage

/* rtl/core/sbd_req_if.sv */
// Request channel: mode and random word, valid/ready handshake.
// Depends on sbd_pkg.
interface sbd_req_if import sbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output mode, output random_word, input ready);
    modport sink   (input valid, input mode, input random_word, output ready);
endinterface

/* rtl/core/sbd_rsp_if.sv */
// Result channel: drawn value and bag status, valid/ready handshake.
// Depends on sbd_pkg.
interface sbd_rsp_if import sbd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_VAL_W-1:0] drawn_value;
    logic                 got_value;
    logic [OUT_VAL_W-1:0] remaining;
    logic                 bag_empty;

    modport source (output valid, output drawn_value, output got_value,
                    output remaining, output bag_empty, input ready);
    modport sink   (input valid, input drawn_value, input got_value,
                    input remaining, input bag_empty, output ready);
endinterface

/* rtl/core/sbd_cfg_if.sv */
// Configuration write channel carrying range_end, valid/ready handshake.
// Depends on sbd_pkg.
interface sbd_cfg_if import sbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_end;

    modport source (output valid, output range_end, input ready);
    modport sink   (input valid, input range_end, output ready);
endinterface

/* rtl/core/shuffle_bag_draw_refill.sv */
// Shuffle bag: draws 1..min(range_end, MAX_ENTRIES)-1 without replacement and refills
// from the picked list. Depends on sbd_pkg, sbd_req_if, sbd_rsp_if and sbd_cfg_if.
//
// One request is worked at a time; the request port is ready only while idle. A draw
// runs a bit-serial restoring remainder (random_word mod bag_count) on one shared
// subtractor, then the bag memory (one write port, one registered read port) is
// streamed one entry per cycle to close the gap. A refill copies one entry per cycle
// from the picked memory. After reset and after every range_end write the bag memory
// is loaded by a fill pass, during which no request is taken; configuration writes
// are always accepted and restart that pass. A finished result waits in an output
// register, so the next request can be taken before it is read.
module shuffle_bag_draw_refill import sbd_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbd_req_if.sink   i_req,
    sbd_rsp_if.source o_rsp,
    sbd_cfg_if.sink   i_cfg
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > RANGE_W) ? CW : RANGE_W;

    t_state r_state, n_state;

    logic [RANGE_W-1:0]   r_range, n_range;
    logic [CW-1:0]        r_bag_cnt, n_bag_cnt;
    logic [CW-1:0]        r_pick_cnt, n_pick_cnt;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic                 r_first, n_first;
    logic                 r_pend, n_pend;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [CW-1:0]        r_rem, n_rem;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [IW-1:0]        r_val, n_val;
    logic                 r_got, n_got;

    logic                 r_out_valid, n_out_valid;
    logic [OUT_VAL_W-1:0] r_out_val, n_out_val;
    logic                 r_out_got, n_out_got;
    logic [OUT_VAL_W-1:0] r_out_rem, n_out_rem;
    logic                 r_out_empty, n_out_empty;

    logic [IW-1:0] r_bag  [MAX_ENTRIES];
    logic [IW-1:0] r_pick [MAX_ENTRIES];
    logic [IW-1:0] r_rd;
    logic [IW-1:0] r_prd;

    logic          bag_we;
    logic [IW-1:0] bag_waddr;
    logic [IW-1:0] bag_wdata;
    logic [IW-1:0] bag_raddr;
    logic          pick_we;

    logic          req_acc;
    logic          cfg_acc;
    logic          out_load;
    logic [LW-1:0] range_lim;
    logic          init_more;
    logic          refill_done;
    logic          shift_more;
    logic [CW:0]   rem_sh;
    logic          rem_ge;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.drawn_value = r_out_val;
    assign o_rsp.got_value   = r_out_got;
    assign o_rsp.remaining   = r_out_rem;
    assign o_rsp.bag_empty   = r_out_empty;

    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_rsp.ready);

    // clamp the range to the bag capacity
    assign range_lim = (LW'(r_range) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES)
                                                         : LW'(r_range);
    assign init_more   = (LW'(r_ptr) + LW'(1)) < range_lim;
    assign refill_done = !r_pend && (r_ptr >= r_pick_cnt);
    assign shift_more  = r_ptr < r_bag_cnt;

    // shared restoring remainder step
    assign rem_sh = {r_rem, r_word[WORD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_bag_cnt};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (!init_more) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_acc) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (r_mode)
                    MODE_DRAW:        n_state = (r_bag_cnt == '0) ? S_OUT : S_DIV;
                    MODE_DRAW_REFILL: n_state = (r_bag_cnt == '0) ? S_REFILL : S_DIV;
                    MODE_REFILL:      n_state = S_REFILL;
                    default:          n_state = S_OUT;
                endcase
            end
            S_REFILL: begin
                if (refill_done) begin
                    if (r_mode == MODE_REFILL || r_bag_cnt == '0) n_state = S_OUT;
                    else n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == BIT_CNT_W'(WORD_W - 1)) n_state = S_FETCH;
            end
            S_FETCH: n_state = S_SHIFT;
            S_SHIFT: begin
                if (!shift_more) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
        if (cfg_acc) n_state = S_INIT;
    end

    // datapath and memory controls
    always_comb begin
        n_range     = r_range;
        n_bag_cnt   = r_bag_cnt;
        n_pick_cnt  = r_pick_cnt;
        n_ptr       = r_ptr;
        n_first     = r_first;
        n_pend      = r_pend;
        n_mode      = r_mode;
        n_word      = r_word;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_val       = r_val;
        n_got       = r_got;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_val   = r_out_val;
        n_out_got   = r_out_got;
        n_out_rem   = r_out_rem;
        n_out_empty = r_out_empty;
        bag_we      = 1'b0;
        bag_waddr   = r_ptr[IW-1:0];
        bag_wdata   = IW'(r_ptr) + IW'(1);
        bag_raddr   = r_ptr[IW-1:0];
        pick_we     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                if (init_more) begin
                    bag_we    = 1'b1;
                    n_ptr     = r_ptr + CW'(1);
                    n_bag_cnt = r_bag_cnt + CW'(1);
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_mode = i_req.mode;
                    n_word = i_req.random_word;
                    n_got  = 1'b0;
                    n_val  = '0;
                end
            end
            S_DECIDE: begin
                n_ptr  = '0;
                n_pend = 1'b0;
                n_rem  = '0;
                n_bit  = '0;
            end
            S_REFILL: begin
                // append picked entries behind the bag tail, one per cycle
                if (r_pend) begin
                    bag_we    = 1'b1;
                    bag_waddr = r_bag_cnt[IW-1:0];
                    bag_wdata = r_prd;
                    n_bag_cnt = r_bag_cnt + CW'(1);
                end
                if (r_ptr < r_pick_cnt) begin
                    n_ptr  = r_ptr + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (refill_done) begin
                    n_pick_cnt = '0;
                    n_rem      = '0;
                    n_bit      = '0;
                end
            end
            S_DIV: begin
                n_rem  = rem_ge ? CW'(rem_sh - {1'b0, r_bag_cnt}) : rem_sh[CW-1:0];
                n_word = {r_word[WORD_W-2:0], 1'b0};
                n_bit  = r_bit + BIT_CNT_W'(1);
            end
            S_FETCH: begin
                bag_raddr = r_rem[IW-1:0];
                n_ptr     = r_rem + CW'(1);
                n_first   = 1'b1;
            end
            S_SHIFT: begin
                // r_rd holds the entry at r_ptr-1: take it or move it down one place
                if (r_first) begin
                    n_val   = r_rd;
                    pick_we = 1'b1;
                end else begin
                    bag_we    = 1'b1;
                    bag_waddr = IW'(r_ptr - CW'(2));
                    bag_wdata = r_rd;
                end
                n_first = 1'b0;
                if (shift_more) begin
                    n_ptr = r_ptr + CW'(1);
                end else begin
                    n_bag_cnt  = r_bag_cnt - CW'(1);
                    n_pick_cnt = r_pick_cnt + CW'(1);
                    n_got      = 1'b1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_got ? OUT_VAL_W'(r_val) : '0;
                    n_out_got   = r_got;
                    n_out_rem   = OUT_VAL_W'(r_bag_cnt);
                    n_out_empty = (r_bag_cnt == '0);
                end
            end
            default: ;
        endcase

        if (cfg_acc) begin
            n_range    = i_cfg.range_end;
            n_bag_cnt  = '0;
            n_pick_cnt = '0;
            n_ptr      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_range     <= RANGE_END_RST;
            r_bag_cnt   <= '0;
            r_pick_cnt  <= '0;
            r_ptr       <= '0;
            r_first     <= 1'b0;
            r_pend      <= 1'b0;
            r_bit       <= '0;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_range     <= n_range;
            r_bag_cnt   <= n_bag_cnt;
            r_pick_cnt  <= n_pick_cnt;
            r_ptr       <= n_ptr;
            r_first     <= n_first;
            r_pend      <= n_pend;
            r_bit       <= n_bit;
            r_got       <= n_got;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_word      <= n_word;
        r_rem       <= n_rem;
        r_val       <= n_val;
        r_out_val   <= n_out_val;
        r_out_got   <= n_out_got;
        r_out_rem   <= n_out_rem;
        r_out_empty <= n_out_empty;
    end

    // bag memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (bag_we) r_bag[bag_waddr] <= bag_wdata;
        r_rd <= r_bag[bag_raddr];
    end

    // picked memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (pick_we) r_pick[r_pick_cnt[IW-1:0]] <= r_rd;
        r_prd <= r_pick[r_ptr[IW-1:0]];
    end

    // the picked count is cleared only at the end of a refill pass or by a range_end write
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_REFILL) |->
            ((CW+1)'(r_bag_cnt) + (CW+1)'(r_pick_cnt) < (CW+1)'(MAX_ENTRIES)))
        else $error("bag and picked counts exceed capacity");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_FETCH) |-> (r_rem < r_bag_cnt))
        else $error("remainder not below bag count");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_bag_cnt != '0 && r_ptr <= r_bag_cnt))
        else $error("shift pass on empty bag or beyond its end");

    a_refill_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |-> (r_ptr <= r_pick_cnt))
        else $error("refill read pointer beyond picked count");

    a_draw_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !shift_more && !cfg_acc)
            |=> (r_pick_cnt == $past(r_pick_cnt) + CW'(1)))
        else $error("draw did not append to picked list");

endmodule
